[rtl/stol_pkg.sv]
// Shared types and constants of the string-to-long parser.
`timescale 1ns / 1ps
`default_nettype none

package stol_pkg;

   // Longest string; the character at this index acts as a terminator.
   localparam int unsigned MAX_LEN = 65535;
   localparam int unsigned IDX_W   = $clog2(MAX_LEN + 1);

   localparam int unsigned ACC_W  = 64;
   localparam int unsigned BASE_W = 6;
   localparam int unsigned PROD_W = ACC_W + BASE_W;
   localparam int unsigned OFS_W  = 16;

   localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [BASE_W-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [ACC_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      DS_NONE,
      DS_DIGITS,
      DS_OVF
   } dstat_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
   } stol_req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic [OFS_W-1:0]        end_offset;
      logic                    overflow;
      logic                    converted;
   } stol_rsp_type;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic              mul_en;
      logic [BASE_W-1:0] digit;
   } mac_ctl_type;

endpackage

`default_nettype wire

[rtl/stol_mac.sv]
// Shared multiply-accumulate unit with sticky overflow check; on overflow the accumulator is held.
`timescale 1ns / 1ps
`default_nettype none

module stol_mac import stol_pkg::*; (
   input  wire logic              clock,
   input  wire mac_ctl_type       ctl,
   input  wire logic [ACC_W-1:0]  acc,
   input  wire logic [BASE_W-1:0] base,
   input  wire logic              negative,
   input  wire dstat_type         status,
   output logic [ACC_W-1:0]       acc_next,
   output dstat_type              status_next
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] sum;
   logic [PROD_W-1:0] lim;
   logic              ovf;

   // step 1: product, registered
   assign prod_in = PROD_W'(acc) * PROD_W'(base);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // step 2: add digit, compare against the signed limit
   assign sum = prod_ff + PROD_W'(ctl.digit);
   assign lim = negative ? PROD_W'(VALUE_MIN) : PROD_W'(VALUE_MAX);
   assign ovf = (status == DS_OVF) || (sum > lim);

   assign status_next = ovf ? DS_OVF : DS_DIGITS;
   assign acc_next    = ovf ? acc : sum[ACC_W-1:0];

endmodule

`default_nettype wire

[rtl/string_to_long_parser_unit.sv]
// Top level of the string-to-long parser: sequencer, state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  stol_req_type {ch, first}
// rsp_      out        rsp_valid/rsp_stall  stol_rsp_type {value, end_offset, overflow, converted}
// csr_      in         csr_write            csr_wdata = radix (6 bits)
//
// One request at a time; req_stall stays high while a character is in work.
// White space, sign and prefix characters pass the dispatch state only. Digits also pass
// the take state and the shared multiply-accumulate unit (product register, then add and compare).
// The '0' ahead of an octal or hex digit string enters the MAC with the next char, unless it is x.
// Terminator: dispatch, take and emit states; emit waits while rsp_stall holds the result register.
// Synchronous reset clears the parse state but for ch_ff, digit_ff and rsp_data_ff; radix resets to 10.

module string_to_long_parser_unit import stol_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stol_req_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stol_rsp_type           rsp_data,
   input  wire logic              csr_write,
   input  wire logic [BASE_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_START,
      PH_ZERO,
      PH_PREFIX,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TAKE,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } seq_type;

   // digit value of a character, 64 when it is no digit at all
   function automatic logic [6:0] digit_of(input logic [7:0] c);
      logic [6:0] d;
      d = 7'd64;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 7'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = 7'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = 7'(c - 8'h41 + 8'd10);
      end
      return d;
   endfunction

   seq_type           state_ff,  state_in;
   phase_type         phase_ff,  phase_in;
   logic              neg_ff,    neg_in;
   logic [ACC_W-1:0]  acc_ff,    acc_in;
   dstat_type         dstat_ff,  dstat_in;
   logic [BASE_W-1:0] base_ff,   base_in;
   logic [IDX_W-1:0]  idx_ff,    idx_in;
   logic [7:0]        ch_ff,     ch_in;
   logic [BASE_W-1:0] digit_ff,  digit_in;
   logic              after_ff,  after_in;   // take the char again after the MAC
   logic [BASE_W-1:0] radix_ff,  radix_in;
   logic              rsp_valid_ff, rsp_valid_in;
   stol_rsp_type      rsp_data_ff,  rsp_data_in;

   mac_ctl_type       mac_ctl;
   logic [ACC_W-1:0]  mac_acc;
   dstat_type         mac_status;

   logic              out_free;
   logic              is_space;
   logic              start_zero;
   logic [BASE_W-1:0] start_base;
   logic [6:0]        dig;
   logic              base_ok;
   logic [IDX_W-1:0]  idx_inc;
   stol_rsp_type      emit_data;

   stol_mac u_mac (
      .clock       (clock),
      .ctl         (mac_ctl),
      .acc         (acc_ff),
      .base        (base_ff),
      .negative    (neg_ff),
      .status      (dstat_ff),
      .acc_next    (mac_acc),
      .status_next (mac_status)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_space   = (ch_ff == CH_SPACE) || (ch_ff >= CH_TAB && ch_ff <= CH_CR);
   assign start_zero = ((radix_ff == RADIX_AUTO) || (radix_ff == BASE_HEX)) &&
                       (ch_ff == CH_ZERO);
   assign start_base = (radix_ff == RADIX_AUTO) ? BASE_DEC : radix_ff;
   assign dig        = digit_of(ch_ff);
   assign base_ok    = (base_ff >= BASE_MIN) && (base_ff <= BASE_MAX);
   assign idx_inc    = idx_ff + IDX_W'(1);

   // result as it stands at the stopping character
   always_comb begin
      if (dstat_ff == DS_OVF) begin
         emit_data.value = neg_ff ? VALUE_MIN : VALUE_MAX;
      end else begin
         emit_data.value = neg_ff ? (ACC_W'(0) - acc_ff) : acc_ff;
      end
      emit_data.end_offset = (dstat_ff != DS_NONE) ? OFS_W'(idx_ff) : '0;
      emit_data.overflow   = (dstat_ff == DS_OVF);
      emit_data.converted  = (dstat_ff != DS_NONE);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      dstat_in     = dstat_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      digit_in     = digit_ff;
      after_in     = after_ff;
      radix_in     = radix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mac_ctl.mul_en = 1'b0;
      mac_ctl.digit  = digit_ff;

      if (csr_write) begin
         radix_in = csr_wdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in    = req_data.ch;
               state_in = ST_DISPATCH;
               if (req_data.first) begin
                  phase_in = PH_SKIP;
                  neg_in   = 1'b0;
                  acc_in   = '0;
                  dstat_in = DS_NONE;
                  base_in  = '0;
                  idx_in   = '0;
               end
            end
         end
         ST_DISPATCH: begin
            // phase decode; the char is in ch_ff
            priority if (phase_ff == PH_DONE) begin
               state_in = ST_IDLE;
            end else if (idx_ff >= IDX_W'(MAX_LEN)) begin
               state_in = ST_EMIT;
            end else if (phase_ff == PH_SKIP && is_space) begin
               idx_in   = idx_inc;
               state_in = ST_IDLE;
            end else if (phase_ff == PH_SKIP && (ch_ff == CH_MINUS || ch_ff == CH_PLUS)) begin
               neg_in   = (ch_ff == CH_MINUS);
               phase_in = PH_START;
               idx_in   = idx_inc;
               state_in = ST_IDLE;
            end else if (phase_ff == PH_SKIP || phase_ff == PH_START) begin
               if (start_zero) begin
                  base_in  = radix_ff;
                  phase_in = PH_ZERO;
                  idx_in   = idx_inc;
                  state_in = ST_IDLE;
               end else begin
                  base_in  = start_base;
                  phase_in = PH_DIGITS;
                  state_in = ST_TAKE;
               end
            end else if (phase_ff == PH_ZERO) begin
               if (ch_ff == CH_X_LO || ch_ff == CH_X_UP) begin
                  base_in  = BASE_HEX;
                  phase_in = PH_PREFIX;
                  idx_in   = idx_inc;
                  state_in = ST_IDLE;
               end else begin
                  // the leading 0 counts as a digit, then the char itself
                  base_in  = (base_ff == RADIX_AUTO) ? BASE_OCT : base_ff;
                  phase_in = PH_DIGITS;
                  digit_in = '0;
                  after_in = 1'b1;
                  state_in = ST_MUL;
               end
            end else begin
               phase_in = PH_DIGITS;
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            if (!base_ok || dig >= 7'(base_ff)) begin
               state_in = ST_EMIT;
            end else begin
               digit_in = dig[BASE_W-1:0];
               after_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = mac_acc;
            dstat_in = mac_status;
            if (after_ff) begin
               after_in = 1'b0;
               state_in = ST_TAKE;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = emit_data;
               phase_in     = PH_DONE;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SKIP;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         dstat_ff     <= DS_NONE;
         base_ff      <= '0;
         idx_ff       <= '0;
         after_ff     <= 1'b0;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         dstat_ff     <= dstat_in;
         base_ff      <= base_in;
         idx_ff       <= idx_in;
         after_ff     <= after_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      digit_ff    <= digit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // the MAC only ever runs with a legal base
   a_mac_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (base_ff >= BASE_MIN && base_ff <= BASE_MAX))
      else $error("MAC committed with illegal base");

   // magnitude never goes past the negative limit
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= VALUE_MIN)
      else $error("accumulator out of range");

   // no conversion means an all-zero response
   a_no_conv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.converted) |->
         (rsp_data.value == '0 && rsp_data.end_offset == '0 && !rsp_data.overflow))
      else $error("empty conversion with nonzero result");

   // a result closes the string
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (phase_ff == PH_DONE && rsp_valid_ff))
      else $error("emit did not close the parse");

   // a digit is always below the active base when it enters the MAC
   a_digit_lt_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (digit_ff < base_ff))
      else $error("digit not below base");
`endif

endmodule

`default_nettype wire
